[rtl/tgis_pkg.sv]
// Shared types, widths and helpers for the timeline gap insert scheduler.
package tgis_pkg;

  localparam int MACH_IN_W = 3;
  localparam int TIME_W    = 32;
  localparam int DUR_W     = 24;
  localparam int TAG_W     = 16;
  localparam int VISIT_W   = 4;
  localparam int POS_W     = 6;

  typedef struct packed {
    logic [TIME_W-1:0]  win_begin;
    logic [TIME_W-1:0]  win_finish;
    logic [TAG_W-1:0]   win_owner;
    logic [VISIT_W-1:0] win_visit;
  } win_t;

  typedef struct packed {
    logic found;
    logic use_pe;
  } fit_t;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_SHIFT  = 5'b00100,
    S_INSERT = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  function automatic logic [TIME_W-1:0] sat_end(input logic [TIME_W-1:0] start,
                                                input logic [DUR_W-1:0]  dur);
    logic [TIME_W:0] sum;
    sum = {1'b0, start} + {{(TIME_W+1-DUR_W){1'b0}}, dur};
    return sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
  endfunction

endpackage

[rtl/tgis_if.sv]
// Request and result channel interfaces of the timeline gap insert scheduler.
interface tgis_in_if;
  logic                           valid;
  logic                           ready;
  logic [tgis_pkg::MACH_IN_W-1:0] machine;
  logic                           first_stage;
  logic [tgis_pkg::TIME_W-1:0]    release_time;
  logic [tgis_pkg::TIME_W-1:0]    prev_stage_end;
  logic [tgis_pkg::DUR_W-1:0]     duration;
  logic [tgis_pkg::TAG_W-1:0]     job_tag;
  logic [tgis_pkg::VISIT_W-1:0]   visit_number;

  modport source (output valid, machine, first_stage, release_time, prev_stage_end,
                  duration, job_tag, visit_number, input ready);
  modport sink (input valid, machine, first_stage, release_time, prev_stage_end,
                duration, job_tag, visit_number, output ready);
endinterface

interface tgis_out_if;
  logic                        valid;
  logic                        ready;
  logic [tgis_pkg::TIME_W-1:0] start_time;
  logic [tgis_pkg::TIME_W-1:0] end_time;
  logic [tgis_pkg::POS_W-1:0]  slot_position;
  logic                        refused;

  modport source (output valid, start_time, end_time, slot_position, refused, input ready);
  modport sink (input valid, start_time, end_time, slot_position, refused, output ready);
endinterface

[rtl/tgis_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module tgis_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/tgis_fit_unit.sv]
// Shared compare unit: decides whether a request fits before one booked window.
module tgis_fit_unit (
  input  logic [tgis_pkg::TIME_W-1:0] lb,
  input  logic [tgis_pkg::TIME_W-1:0] pe,
  input  logic [tgis_pkg::TIME_W-1:0] ready,
  input  logic [tgis_pkg::TIME_W:0]   ready_dur,
  input  logic [tgis_pkg::DUR_W-1:0]  dur,
  input  logic                        first,
  output tgis_pkg::fit_t              fit
);

  logic                        skip;
  logic                        gap_ok;
  logic [tgis_pkg::TIME_W:0]   pe_dur;

  always_comb begin
    pe_dur     = {1'b0, pe} + {{(tgis_pkg::TIME_W+1-tgis_pkg::DUR_W){1'b0}}, dur};
    skip       = {1'b0, lb} < ready_dur;
    gap_ok     = (ready < pe) && (pe_dur <= {1'b0, lb});
    fit.found  = !skip && (first || gap_ok || (pe <= ready));
    fit.use_pe = !skip && !first && gap_ok;
  end

endmodule

[rtl/timeline_gap_insert_scheduler_core.sv]
// Top level: first-fit gap insertion scheduler over per-machine window lists.
//
//  channel | dir | handshake          | payload
//  in_ch   | in  | valid/ready        | machine, first_stage, release_time, prev_stage_end,
//          |     |                    | duration, job_tag, visit_number
//  out_ch  | out | valid/ready        | start_time, end_time, slot_position, refused
//
//  One request at a time; in_ch.ready is high only while idle.
//  A refused request goes straight to retire and an empty list straight to insert; otherwise
//  the core scans the windows, shifts the later ones when the window lands inside the list,
//  then inserts and retires. The scan and the shift share the single RAM read port and each
//  use it once per cycle.
//  Reset clears the per-machine counts and the output valid flag; window storage is not
//  cleared. A stalled result holds in the output register and the core waits to retire.
module timeline_gap_insert_scheduler_core #(
  parameter int NUM_MACHINES      = 8,
  parameter int SLOTS_PER_MACHINE = 32
) (
  input logic        clk,
  input logic        rst_n,
  tgis_in_if.sink    in_ch,
  tgis_out_if.source out_ch
);

  localparam int SLOT_AW   = $clog2(SLOTS_PER_MACHINE);
  localparam int CNT_W     = $clog2(SLOTS_PER_MACHINE + 1);
  localparam int MACH_W    = (NUM_MACHINES > 1) ? $clog2(NUM_MACHINES) : 1;
  localparam int ADDR_W    = MACH_W + SLOT_AW;
  localparam int RAM_DEPTH = 1 << ADDR_W;
  localparam int TW        = tgis_pkg::TIME_W;
  localparam int MCMP_W    = 8;

  tgis_pkg::state_t state_r, state_nxt;

  logic [MACH_W-1:0]             mach_r, mach_nxt;
  logic [CNT_W-1:0]              cnt_r, cnt_nxt;
  logic [TW-1:0]                 ready_r, ready_nxt;
  logic [TW:0]                   rdy_dur_r, rdy_dur_nxt;
  logic [tgis_pkg::DUR_W-1:0]    dur_r, dur_nxt;
  logic [tgis_pkg::TAG_W-1:0]    tag_r, tag_nxt;
  logic [tgis_pkg::VISIT_W-1:0]  visit_r, visit_nxt;
  logic [CNT_W-1:0]              idx_r, idx_nxt;
  logic                          cmp_v_r, cmp_v_nxt;
  logic [CNT_W-1:0]              cmp_idx_r, cmp_idx_nxt;
  logic                          more_r, more_nxt;
  logic [TW-1:0]                 pe_r, pe_nxt;
  logic [CNT_W-1:0]              pos_r, pos_nxt;
  logic [TW-1:0]                 start_r, start_nxt;
  logic                          refused_r, refused_nxt;

  logic                          out_valid_r;
  logic [TW-1:0]                 out_start_r;
  logic [TW-1:0]                 out_end_r;
  logic [tgis_pkg::POS_W-1:0]    out_pos_r;
  logic                          out_refused_r;
  logic                          out_load;

  logic [CNT_W-1:0]              booked_r [NUM_MACHINES];

  logic                          accept;
  logic                          mach_ok;
  logic [MACH_W+tgis_pkg::MACH_IN_W-1:0] mach_ext;
  logic [MACH_W-1:0]             in_mach;
  logic [CNT_W-1:0]              in_cnt;
  logic [TW-1:0]                 in_ready_time;
  logic [TW-1:0]                 end_val;
  logic [CNT_W+tgis_pkg::POS_W-1:0] pos_ext;

  logic                          ram_we;
  logic [ADDR_W-1:0]             ram_waddr;
  logic [ADDR_W-1:0]             ram_raddr;
  tgis_pkg::win_t                ram_wdata;
  tgis_pkg::win_t                ram_rdata;
  tgis_pkg::fit_t                fit;

  assign in_ch.ready = (state_r == tgis_pkg::S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;

  assign mach_ok       = {{(MCMP_W-tgis_pkg::MACH_IN_W){1'b0}}, in_ch.machine}
                         < MCMP_W'(NUM_MACHINES);
  assign mach_ext      = {{MACH_W{1'b0}}, in_ch.machine};
  assign in_mach       = mach_ext[MACH_W-1:0];
  assign in_cnt        = mach_ok ? booked_r[in_mach] : '0;
  assign in_ready_time = in_ch.first_stage ? in_ch.release_time : in_ch.prev_stage_end;
  assign end_val       = tgis_pkg::sat_end(start_r, dur_r);
  assign pos_ext       = {{tgis_pkg::POS_W{1'b0}}, pos_r};

  assign ram_raddr = {mach_r, idx_r[SLOT_AW-1:0]};
  assign ram_we    = (state_r == tgis_pkg::S_INSERT) ||
                     ((state_r == tgis_pkg::S_SHIFT) && cmp_v_r);

  always_comb begin
    if (state_r == tgis_pkg::S_INSERT) begin
      ram_waddr            = {mach_r, pos_r[SLOT_AW-1:0]};
      ram_wdata.win_begin  = start_r;
      ram_wdata.win_finish = end_val;
      ram_wdata.win_owner  = tag_r;
      ram_wdata.win_visit  = visit_r;
    end else begin
      ram_waddr = {mach_r, cmp_idx_r[SLOT_AW-1:0]};
      ram_wdata = ram_rdata;
    end
  end

  tgis_ram #(
    .WIDTH ($bits(tgis_pkg::win_t)),
    .DEPTH (RAM_DEPTH)
  ) u_win_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tgis_fit_unit u_fit (
    .lb        (ram_rdata.win_begin),
    .pe        (pe_r),
    .ready     (ready_r),
    .ready_dur (rdy_dur_r),
    .dur       (dur_r),
    .first     (cmp_idx_r == '0),
    .fit       (fit)
  );

  always_comb begin
    state_nxt   = state_r;
    mach_nxt    = mach_r;
    cnt_nxt     = cnt_r;
    ready_nxt   = ready_r;
    rdy_dur_nxt = rdy_dur_r;
    dur_nxt     = dur_r;
    tag_nxt     = tag_r;
    visit_nxt   = visit_r;
    idx_nxt     = idx_r;
    cmp_v_nxt   = cmp_v_r;
    cmp_idx_nxt = cmp_idx_r;
    more_nxt    = more_r;
    pe_nxt      = pe_r;
    pos_nxt     = pos_r;
    start_nxt   = start_r;
    refused_nxt = refused_r;
    out_load    = 1'b0;
    case (state_r)
      tgis_pkg::S_IDLE: begin
        if (accept) begin
          mach_nxt    = in_mach;
          cnt_nxt     = in_cnt;
          ready_nxt   = in_ready_time;
          rdy_dur_nxt = {1'b0, in_ready_time}
                        + {{(TW+1-tgis_pkg::DUR_W){1'b0}}, in_ch.duration};
          dur_nxt     = in_ch.duration;
          tag_nxt     = in_ch.job_tag;
          visit_nxt   = in_ch.visit_number;
          idx_nxt     = '0;
          cmp_v_nxt   = 1'b0;
          cmp_idx_nxt = '0;
          refused_nxt = !mach_ok || (in_cnt == CNT_W'(SLOTS_PER_MACHINE));
          if (refused_nxt) begin
            state_nxt = tgis_pkg::S_DONE;
          end else if (in_cnt == '0) begin
            start_nxt = in_ready_time;
            pos_nxt   = '0;
            state_nxt = tgis_pkg::S_INSERT;
          end else begin
            state_nxt = tgis_pkg::S_SCAN;
          end
        end
      end
      tgis_pkg::S_SCAN: begin
        idx_nxt     = idx_r + 1'b1;
        cmp_v_nxt   = idx_r < cnt_r;
        cmp_idx_nxt = idx_r;
        if (cmp_v_r) begin
          if (fit.found) begin
            start_nxt = fit.use_pe ? pe_r : ready_r;
            pos_nxt   = cmp_idx_r;
            idx_nxt   = cnt_r - 1'b1;
            cmp_v_nxt = 1'b0;
            more_nxt  = 1'b1;
            state_nxt = tgis_pkg::S_SHIFT;
          end else begin
            pe_nxt = ram_rdata.win_finish;
            if (cmp_idx_r == cnt_r - 1'b1) begin
              start_nxt = (ram_rdata.win_finish > ready_r) ? ram_rdata.win_finish : ready_r;
              pos_nxt   = cnt_r;
              state_nxt = tgis_pkg::S_INSERT;
            end
          end
        end
      end
      tgis_pkg::S_SHIFT: begin
        if (more_r) begin
          idx_nxt     = idx_r - 1'b1;
          more_nxt    = idx_r != pos_r;
          cmp_v_nxt   = 1'b1;
          cmp_idx_nxt = idx_r + 1'b1;
        end else begin
          cmp_v_nxt = 1'b0;
        end
        if (cmp_v_r && !more_r) begin
          state_nxt = tgis_pkg::S_INSERT;
        end
      end
      tgis_pkg::S_INSERT: begin
        state_nxt = tgis_pkg::S_DONE;
      end
      tgis_pkg::S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = tgis_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = tgis_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tgis_pkg::S_IDLE;
      cmp_v_r     <= 1'b0;
      more_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int m = 0; m < NUM_MACHINES; m++) begin
        booked_r[m] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      cmp_v_r <= cmp_v_nxt;
      more_r  <= more_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == tgis_pkg::S_INSERT) begin
        booked_r[mach_r] <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    mach_r    <= mach_nxt;
    cnt_r     <= cnt_nxt;
    ready_r   <= ready_nxt;
    rdy_dur_r <= rdy_dur_nxt;
    dur_r     <= dur_nxt;
    tag_r     <= tag_nxt;
    visit_r   <= visit_nxt;
    idx_r     <= idx_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    pe_r      <= pe_nxt;
    pos_r     <= pos_nxt;
    start_r   <= start_nxt;
    refused_r <= refused_nxt;
    if (out_load) begin
      out_start_r   <= refused_r ? '0 : start_r;
      out_end_r     <= refused_r ? '0 : end_val;
      out_pos_r     <= refused_r ? '0 : pos_ext[tgis_pkg::POS_W-1:0];
      out_refused_r <= refused_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.start_time    = out_start_r;
  assign out_ch.end_time      = out_end_r;
  assign out_ch.slot_position = out_pos_r;
  assign out_ch.refused       = out_refused_r;

  a_insert_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tgis_pkg::S_INSERT) |-> (cnt_r < CNT_W'(SLOTS_PER_MACHINE)))
    else $error("insert into a full window list");

  a_insert_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tgis_pkg::S_INSERT) |-> (pos_r <= cnt_r))
    else $error("insert position beyond list end");

  a_write_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> ((state_r == tgis_pkg::S_SHIFT) || (state_r == tgis_pkg::S_INSERT)))
    else $error("window write outside shift or insert");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == tgis_pkg::S_DONE))
    else $error("result raised outside retire");

endmodule
